FILE: rtl/core/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared widths, constants and register codes of the line follower pid unit.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int SENSOR_COUNT    = 7;
  localparam int SPEED_FRAC_BITS = 12;

  localparam int GAIN_W  = 19;
  localparam int SPEED_W = 13;
  localparam int POS_W   = 8;
  localparam int INTEG_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = ADDR_W - 2;

  // product and sum widths of the pid datapath
  localparam int P_PROD_W = GAIN_W + POS_W;
  localparam int I_PROD_W = GAIN_W + INTEG_W;
  localparam int D_PROD_W = GAIN_W + POS_W;
  localparam int POWER_W  = I_PROD_W + 1;
  localparam int SUM_W    = POWER_W + 1;

  localparam logic signed [POS_W-1:0] JUNCTION_POS = -8'sd100;

  localparam logic [GAIN_W-1:0]  GAIN_P_RESET    = GAIN_W'(10 << SPEED_FRAC_BITS);
  localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = SPEED_W'(1 << SPEED_FRAC_BITS);

  // register indexes, byte address is 4 * index
  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_SPEED = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED = 3'd4;

  typedef logic [SENSOR_COUNT-1:0] pattern_t;
  typedef logic [SPEED_W-1:0]      speed_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

FILE: rtl/core/lfp_sensor_if.sv
// ----------------------------------------------------------------------------
// lfp_sensor_if
// Request channel carrying one line sensor sample.
// ----------------------------------------------------------------------------
interface lfp_sensor_if;
  import lfp_pkg::*;

  logic     valid;
  logic     ready;
  pattern_t line_pattern;

  modport source (output valid, output line_pattern, input ready);
  modport sink   (input valid, input line_pattern, output ready);

endinterface

FILE: rtl/core/lfp_result_if.sv
// ----------------------------------------------------------------------------
// lfp_result_if
// Result channel carrying wheel speeds and the decoded line position.
// ----------------------------------------------------------------------------
interface lfp_result_if;
  import lfp_pkg::*;

  logic   valid;
  logic   ready;
  speed_t left_speed;
  speed_t right_speed;
  pos_t   line_position;
  logic   junction;

  modport source (output valid, output left_speed, output right_speed,
                  output line_position, output junction, input ready);
  modport sink   (input valid, input left_speed, input right_speed,
                  input line_position, input junction, output ready);

endinterface

FILE: rtl/core/line_follow_pid_unit.sv
// ----------------------------------------------------------------------------
// line_follow_pid_unit
// PID line follower: decodes a sensor sample and drives two wheel speeds.
// ----------------------------------------------------------------------------
// throughput: one request per cycle unless the result side stalls; the
//   path is input reg, decode and integral update, three gain products,
//   power sum, clamp into output reg
// each stage stalls only when full and the stage after it cannot move
// reset (rst, synchronous): pipeline empty, previous position and integral
//   zero, gains and speed limits at their default values
module line_follow_pid_unit (
  input  logic                       clk,
  input  logic                       rst,
  lfp_sensor_if.sink                 sensor,
  lfp_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfp_pkg::ADDR_W-1:0] paddr,
  input  logic [lfp_pkg::DATA_W-1:0] pwdata,
  output logic [lfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lfp_pkg::*;

  localparam int CENTER = SENSOR_COUNT / 2;
  localparam int BIT_W  = $clog2(SENSOR_COUNT);

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  speed_t                   min_speed, max_speed;

  // loop state
  pos_t                      previous_position;
  logic signed [INTEG_W-1:0] position_integral;

  // pipeline registers
  logic                      s1_valid, s2_valid, s3_valid, s4_valid, res_valid;
  pattern_t                  s1_pattern;
  pos_t                      s2_pos, s2_deriv, s3_pos, s4_pos;
  logic                      s2_junction, s3_junction, s4_junction;
  logic signed [INTEG_W-1:0] s2_integ;
  logic signed [P_PROD_W-1:0] s3_p_prod;
  logic signed [I_PROD_W-1:0] s3_i_prod;
  logic signed [D_PROD_W-1:0] s3_d_prod;
  logic signed [POWER_W-1:0]  s4_power;
  speed_t                    res_left, res_right;
  pos_t                      res_pos;
  logic                      res_junction;

  logic res_en, s4_en, s3_en, s2_en, s1_en;

  logic                      dec_onehot;
  logic [BIT_W-1:0]          dec_bit;
  pos_t                      dec_pos;
  pos_t                      deriv_next;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [P_PROD_W-1:0] p_prod_next;
  logic signed [I_PROD_W-1:0] i_prod_next;
  logic signed [D_PROD_W-1:0] d_prod_next;
  logic signed [POWER_W-1:0]  power_next;
  logic signed [SUM_W-1:0]    min_ext, max_ext, right_sum, left_sum;

  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_idx;

  function automatic speed_t clamp_speed(input logic signed [SUM_W-1:0] v,
                                         input logic signed [SUM_W-1:0] lo,
                                         input logic signed [SUM_W-1:0] hi);
    logic signed [SUM_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[SPEED_W-1:0];
  endfunction

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= GAIN_P_RESET;
      gain_i    <= '0;
      gain_d    <= '0;
      min_speed <= '0;
      max_speed <= MAX_SPEED_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:    gain_p    <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i    <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d    <= pwdata[GAIN_W-1:0];
        REG_MIN_SPEED: min_speed <= pwdata[SPEED_W-1:0];
        REG_MAX_SPEED: max_speed <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:    prdata = DATA_W'(gain_p[GAIN_W-1:0]);
      REG_GAIN_I:    prdata = DATA_W'(gain_i[GAIN_W-1:0]);
      REG_GAIN_D:    prdata = DATA_W'(gain_d[GAIN_W-1:0]);
      REG_MIN_SPEED: prdata = DATA_W'(min_speed);
      REG_MAX_SPEED: prdata = DATA_W'(max_speed);
      default:       prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  assign res_en = !res_valid || result.ready;
  assign s4_en  = !s4_valid || res_en;
  assign s3_en  = !s3_valid || s4_en;
  assign s2_en  = !s2_valid || s3_en;
  assign s1_en  = !s1_valid || s2_en;
  assign sensor.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_en)  s1_valid  <= sensor.valid;
      if (s2_en)  s2_valid  <= s1_valid;
      if (s3_en)  s3_valid  <= s2_valid;
      if (s4_en)  s4_valid  <= s3_valid;
      if (res_en) res_valid <= s4_valid;
    end
  end

  // ---------------- stage 1: decode and loop state ----------------
  always_comb begin
    dec_onehot = (s1_pattern != '0) && ((s1_pattern & (s1_pattern - 1'b1)) == '0);
    dec_bit    = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (s1_pattern[i]) begin
        dec_bit = dec_bit | BIT_W'(i);
      end
    end
    dec_pos = dec_onehot ? (POS_W'(CENTER) - POS_W'(dec_bit)) : JUNCTION_POS;
  end

  assign deriv_next = dec_pos - previous_position;
  assign integ_sum  = (INTEG_W+1)'(position_integral) + (INTEG_W+1)'(dec_pos);

  // saturate the integral to 16 bits
  always_comb begin
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_next = {integ_sum[INTEG_W], {(INTEG_W-1){!integ_sum[INTEG_W]}}};
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_position <= '0;
      position_integral <= '0;
    end else if (s1_valid && s2_en) begin
      previous_position <= dec_pos;
      position_integral <= integ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_pattern <= sensor.line_pattern;
    end
    if (s2_en) begin
      s2_pos      <= dec_pos;
      s2_deriv    <= deriv_next;
      s2_integ    <= integ_next;
      s2_junction <= !dec_onehot;
    end
  end

  // ---------------- stage 2: gain products ----------------
  assign p_prod_next = P_PROD_W'(gain_p) * P_PROD_W'(s2_pos);
  assign i_prod_next = I_PROD_W'(gain_i) * I_PROD_W'(s2_integ);
  assign d_prod_next = D_PROD_W'(gain_d) * D_PROD_W'(s2_deriv);

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_p_prod   <= p_prod_next;
      s3_i_prod   <= i_prod_next;
      s3_d_prod   <= d_prod_next;
      s3_pos      <= s2_pos;
      s3_junction <= s2_junction;
    end
  end

  // ---------------- stage 3: power sum ----------------
  assign power_next = POWER_W'(s3_p_prod) + POWER_W'(s3_i_prod) + POWER_W'(s3_d_prod);

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_power    <= power_next;
      s4_pos      <= s3_pos;
      s4_junction <= s3_junction;
    end
  end

  // ---------------- stage 4: wheel speeds ----------------
  assign min_ext   = SUM_W'($signed({1'b0, min_speed}));
  assign max_ext   = SUM_W'($signed({1'b0, max_speed}));
  assign right_sum = max_ext + SUM_W'(s4_power);
  assign left_sum  = max_ext - SUM_W'(s4_power);

  always_ff @(posedge clk) begin
    if (res_en) begin
      res_right    <= clamp_speed(right_sum, min_ext, max_ext);
      res_left     <= clamp_speed(left_sum, min_ext, max_ext);
      res_pos      <= s4_pos;
      res_junction <= s4_junction;
    end
  end

  assign result.valid         = res_valid;
  assign result.left_speed    = res_left;
  assign result.right_speed   = res_right;
  assign result.line_position = res_pos;
  assign result.junction      = res_junction;

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_junction_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_junction == (res_pos == JUNCTION_POS)))
    else $error("junction flag disagrees with position");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_junction) |-> (res_pos >= -8'sd3 && res_pos <= 8'sd3))
    else $error("decoded position out of range");

  a_prev_tracks: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (previous_position == s2_pos))
    else $error("previous position lost track of the newest request");

endmodule

FILE: verif/line_follow_pid_unit_test.sv
// ----------------------------------------------------------------------------
// line_follow_pid_unit_test
// Self-checking bench for the pid line follower. Sensor samples go in over
// a valid/ready channel in random bursts, in some phases without gaps,
// while the result side stalls on its own pattern. Gains and speed limits
// are set over the register port between phases. Every wheel command that
// comes out is compared against the typed command of its directed row or
// against a predictor tracking the previous position and saturating integral.
// ----------------------------------------------------------------------------
module line_follow_pid_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam int NUM_PHASES   = 9;
  localparam int GAIN_MIN     = -(1 << (GAIN_W - 1));
  localparam int GAIN_MAX     = (1 << (GAIN_W - 1)) - 1;
  localparam int FULL_SPEED   = 1 << SPEED_FRAC_BITS;
  localparam int SPEED_TOP    = (1 << SPEED_W) - 1;
  localparam int INTEG_MAX    = (1 << (INTEG_W - 1)) - 1;
  localparam int INTEG_MIN    = -(1 << (INTEG_W - 1));
  localparam logic [IDX_W-1:0] REG_UNMAPPED = REG_MAX_SPEED + 3'd1;

  typedef struct packed {
    speed_t left_speed;
    speed_t right_speed;
    pos_t   line_position;
    logic   junction;
  } wheel_cmd_t;

  typedef struct packed {
    pattern_t   pat;
    logic       typed;
    wheel_cmd_t cmd;
  } sample_row_t;

  // rows marked typed carry the command expected with the reset settings
  localparam sample_row_t DIR_ROWS [16] = '{
    '{7'h00, 1'b1, '{13'd4096, 13'd0,    JUNCTION_POS, 1'b1}},
    '{7'h01, 1'b1, '{13'd0,    13'd4096, 8'sd3,        1'b0}},
    '{7'h02, 1'b1, '{13'd0,    13'd4096, 8'sd2,        1'b0}},
    '{7'h04, 1'b1, '{13'd0,    13'd4096, 8'sd1,        1'b0}},
    '{7'h08, 1'b1, '{13'd4096, 13'd4096, 8'sd0,        1'b0}},
    '{7'h10, 1'b1, '{13'd4096, 13'd0,    -8'sd1,       1'b0}},
    '{7'h20, 1'b1, '{13'd4096, 13'd0,    -8'sd2,       1'b0}},
    '{7'h40, 1'b1, '{13'd4096, 13'd0,    -8'sd3,       1'b0}},
    '{7'h7F, 1'b1, '{13'd4096, 13'd0,    JUNCTION_POS, 1'b1}},
    '{7'h16, 1'b1, '{13'd4096, 13'd0,    JUNCTION_POS, 1'b1}},
    '{7'h32, 1'b1, '{13'd4096, 13'd0,    JUNCTION_POS, 1'b1}},
    '{7'h64, 1'b1, '{13'd4096, 13'd0,    JUNCTION_POS, 1'b1}},
    '{7'h03, 1'b1, '{13'd4096, 13'd0,    JUNCTION_POS, 1'b1}},
    '{7'h41, 1'b0, '0},
    '{7'h2A, 1'b0, '0},
    '{7'h55, 1'b0, '0}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lfp_sensor_if sensor_ch ();
  lfp_result_if result_ch ();

  line_follow_pid_unit uut (
    .clk     (clk),
    .rst     (rst),
    .sensor  (sensor_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the loop state and the settings
  int k_p       = $signed(GAIN_P_RESET);
  int k_i       = 0;
  int k_d       = 0;
  int floor_spd = 0;
  int ceil_spd  = MAX_SPEED_RESET;
  int trail_pos = 0;
  int integ_acc = 0;

  wheel_cmd_t pending_cmds [$];
  int         sent_total  = 0;
  int         seen_total  = 0;
  int         fault_count = 0;
  int         cycle_count = 0;

  // tag driven along with each request so the monitor knows its typed value
  logic       tag_typed;
  wheel_cmd_t tag_cmd;

  int burst_left  = 0;
  bit steady_feed = 1'b0;
  int track_bit   = 3;
  int rx_cycle    = 0;
  int stall_mode  = 0;

  function automatic speed_t clamp_speed(longint v);
    if (v < floor_spd) return speed_t'(floor_spd);
    if (v > ceil_spd) return speed_t'(ceil_spd);
    return speed_t'(v);
  endfunction

  function automatic wheel_cmd_t steer_for(pattern_t pat);
    wheel_cmd_t c;
    bit         one_hot;
    int         pos;
    int         b;
    int         diff;
    longint     acc;
    longint     power;
    one_hot = (pat != 0) && ((pat & (pat - 1)) == 0);
    pos = JUNCTION_POS;
    if (one_hot) begin
      b = 0;
      while (!pat[b]) b++;
      pos = SENSOR_COUNT / 2 - b;
    end
    diff = pos - trail_pos;
    acc = longint'(integ_acc) + pos;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ_acc = int'(acc);
    trail_pos = pos;
    power = longint'(k_p) * pos + longint'(k_i) * acc + longint'(k_d) * diff;
    c.right_speed   = clamp_speed(longint'(ceil_spd) + power);
    c.left_speed    = clamp_speed(longint'(ceil_spd) - power);
    c.line_position = pos_t'(pos);
    c.junction      = !one_hot;
    return c;
  endfunction

  // a line drifting one sensor at a time, with junctions at junction_pct percent and some noise
  function automatic pattern_t next_pattern(int junction_pct);
    int roll;
    int b;
    int c;
    roll = $urandom_range(0, 99);
    if (roll < junction_pct) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        default: begin
          b = $urandom_range(0, SENSOR_COUNT - 1);
          c = (b + 1 + int'($urandom_range(0, SENSOR_COUNT - 2))) % SENSOR_COUNT;
          return pattern_t'($urandom) | (pattern_t'(1) << b) | (pattern_t'(1) << c);
        end
      endcase
    end
    if (roll < junction_pct + 10) return pattern_t'($urandom);
    track_bit += int'($urandom_range(0, 2)) - 1;
    if (track_bit < 0) track_bit = 0;
    if (track_bit > SENSOR_COUNT - 1) track_bit = SENSOR_COUNT - 1;
    return pattern_t'(1) << track_bit;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    logic signed [GAIN_W-1:0] g;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    g = val[GAIN_W-1:0];
    case (idx)
      REG_GAIN_P:    k_p = g;
      REG_GAIN_I:    k_i = g;
      REG_GAIN_D:    k_d = g;
      REG_MIN_SPEED: floor_spd = val[SPEED_W-1:0];
      REG_MAX_SPEED: ceil_spd = val[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(pattern_t pat, logic typed, wheel_cmd_t cmd);
    int gap;
    if (burst_left == 0) begin
      gap = steady_feed ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        sensor_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    sensor_ch.valid        <= 1'b1;
    sensor_ch.line_pattern <= pat;
    tag_typed              <= typed;
    tag_cmd                <= cmd;
    do @(posedge clk); while (!sensor_ch.ready);
    sent_total++;
    burst_left--;
  endtask

  task automatic drain_requests();
    sensor_ch.valid <= 1'b0;
    burst_left = 0;
    while (seen_total != sent_total) @(posedge clk);
  endtask

  // result side: ready follows one of five stall patterns, redrawn at random
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 150 == 0) stall_mode = $urandom_range(0, 4);
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 99) >= 25);
      2: result_ch.ready <= ($urandom_range(0, 99) >= 60);
      3: result_ch.ready <= (rx_cycle % 5 >= 3);
      default: result_ch.ready <= (rx_cycle % 9 == 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    wheel_cmd_t want;
    wheel_cmd_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (sensor_ch.valid && sensor_ch.ready) begin
        want = steer_for(sensor_ch.line_pattern);
        if (tag_typed) want = tag_cmd;
        pending_cmds.push_back(want);
      end
      if (result_ch.valid && result_ch.ready) begin
        seen_total++;
        got = '{result_ch.left_speed, result_ch.right_speed,
                result_ch.line_position, result_ch.junction};
        if (pending_cmds.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("result with no request pending: %p", got);
        end else begin
          want = pending_cmds.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("mismatch: left %0d/%0d right %0d/%0d pos %0d/%0d junction %0b/%0b",
                       want.left_speed, got.left_speed, want.right_speed, got.right_speed,
                       want.line_position, got.line_position, want.junction, got.junction);
          end
        end
      end
    end
  end

  initial begin
    int ph;
    int i;
    int count;
    int jpct;
    int gp;
    int gi;
    int gd;
    int lo;
    int hi;
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    sensor_ch.valid        <= 1'b0;
    sensor_ch.line_pattern <= '0;
    tag_typed              <= 1'b0;
    tag_cmd                <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[r]) send_sample(DIR_ROWS[r].pat, DIR_ROWS[r].typed, DIR_ROWS[r].cmd);
    drain_requests();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      count       = 55;
      jpct        = 8;
      steady_feed = 1'b0;
      case (ph)
        0: begin
          gp = GAIN_MIN; gi = 0; gd = GAIN_MAX; lo = 0; hi = FULL_SPEED;
        end
        1: begin
          gp = GAIN_MAX; gi = GAIN_MIN; gd = GAIN_MIN; lo = FULL_SPEED; hi = FULL_SPEED;
          jpct = 30;
        end
        2: begin
          gp = int'($urandom_range(0, 16384)) - 8192;
          gi = int'($urandom_range(0, 32)) - 16;
          gd = int'($urandom_range(0, 16384)) - 8192;
          lo = $urandom_range(0, 1500);
          hi = $urandom_range(2500, FULL_SPEED);
        end
        3: begin
          // minimum above maximum
          gp = int'($urandom_range(0, 4096)) - 2048;
          gi = int'($urandom_range(0, 8)) - 4;
          gd = int'($urandom_range(0, 4096)) - 2048;
          lo = $urandom_range(2049, FULL_SPEED);
          hi = $urandom_range(0, 2048);
        end
        4: begin
          gp = int'($urandom_range(0, 2048)) - 1024;
          gi = 0;
          gd = int'($urandom_range(0, 8192)) - 4096;
          lo = 0;
          hi = SPEED_TOP;
          steady_feed = 1'b1;
        end
        5: begin
          gp = $urandom; gi = $urandom; gd = $urandom; lo = $urandom; hi = $urandom;
        end
        6: begin
          gp = int'($urandom_range(0, 1200)) - 600;
          gi = int'($urandom_range(0, 4)) - 2;
          gd = int'($urandom_range(0, 1200)) - 600;
          lo = $urandom_range(0, 400);
          hi = $urandom_range(3600, FULL_SPEED);
          steady_feed = 1'b1;
        end
        7: begin
          // junction flood drives the integral into saturation
          gp = int'($urandom_range(0, 128)) - 64;
          gi = 1;
          gd = int'($urandom_range(0, 128)) - 64;
          lo = 0;
          hi = FULL_SPEED;
          jpct = 95;
          count = 350;
        end
        default: begin
          gp = int'($urandom_range(0, 4096)) - 2048;
          gi = 1;
          gd = int'($urandom_range(0, 4096)) - 2048;
          lo = 0;
          hi = FULL_SPEED;
          count = 45;
        end
      endcase
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_MIN_SPEED, lo);
      write_reg(REG_MAX_SPEED, hi);
      if (ph == 4 || ph == 5)
        write_reg(IDX_W'(REG_UNMAPPED + $urandom_range(0, 2)), $urandom);
      for (i = 0; i < count; i++) begin
        // let the pipeline empty out once in mid-stream
        if (ph == 2 && i == count / 2) drain_requests();
        send_sample(next_pattern(jpct), 1'b0, '0);
      end
      drain_requests();
    end

    repeat (12) @(posedge clk);
    if (fault_count == 0 && pending_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
